// File: src/tlpq_pkg.sv
// Shared types and constants for the three-level priority queue.
package tlpq_pkg;

	localparam int CAPACITY = 8;
	localparam int LEVELS   = 3;
	localparam int DATA_W   = 32;
	localparam int OCC_W    = 4;
	localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int LV_W     = 2;
	localparam int ADDR_W   = $clog2(LEVELS * CAPACITY);

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_BAD_PRI = 2'd3;

	localparam logic [1:0] PRI_NONE = 2'd0;

	typedef struct packed {
		logic                     command;
		logic signed [DATA_W-1:0] item_value;
		logic [1:0]               priority_level;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic [1:0]               status;
		logic                     now_empty;
		logic                     now_full;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} dp_ctl_t;

endpackage

// File: src/tlpq_ctrl.sv
// Command sequencer: accept, execute, respond.
module tlpq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output tlpq_pkg::dp_ctl_t ctl
);
	import tlpq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q == S_EXEC);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				// a new transaction may start while the result is shown
				state_d = accept ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ctl.load = accept;
	assign ctl.exec = (state_q == S_EXEC);
	assign done     = (state_q == S_RESP);

endmodule

// File: src/tlpq_dp.sv
// Datapath: level pointers, counts, value store and result registers.
module tlpq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  tlpq_pkg::dp_ctl_t ctl,
	input  tlpq_pkg::req_t    req,
	output tlpq_pkg::rsp_t    rsp
);
	import tlpq_pkg::*;

	logic              [DATA_W-1:0] mem [LEVELS*CAPACITY];
	req_t                           req_q;
	logic [PTR_W-1:0]               head_q  [LEVELS];
	logic [PTR_W-1:0]               tail_q  [LEVELS];
	logic [CNT_W-1:0]               lcnt_q  [LEVELS];
	logic [CNT_W-1:0]               total_q;
	logic [1:0]                     status_q;
	logic                           deq_ok_q;
	logic [DATA_W-1:0]              rd_data_q;

	logic              is_full;
	logic              is_empty;
	logic              enq_go;
	logic              deq_go;
	logic [1:0]        status_d;
	logic [LV_W-1:0]   enq_lv;
	logic [LV_W-1:0]   deq_lv;
	logic [PTR_W-1:0]  tail_cur;
	logic [PTR_W-1:0]  head_cur;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
		adv = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign is_full  = (total_q >= CNT_W'(CAPACITY));
	assign is_empty = (total_q == '0);
	assign enq_lv   = req_q.priority_level - LV_W'(1);
	// strict priority: highest non-empty level wins
	assign deq_lv   = (lcnt_q[2] != '0) ? LV_W'(2) :
	                  (lcnt_q[1] != '0) ? LV_W'(1) : LV_W'(0);

	always_comb begin
		enq_go   = 1'b0;
		deq_go   = 1'b0;
		status_d = ST_OK;
		if (req_q.command == CMD_ENQ) begin
			if (is_full)                                status_d = ST_FULL;
			else if (req_q.priority_level == PRI_NONE)  status_d = ST_BAD_PRI;
			else                                        enq_go   = ctl.exec;
		end else begin
			if (is_empty) status_d = ST_EMPTY;
			else          deq_go   = ctl.exec;
		end
	end

	assign tail_cur = tail_q[enq_lv];
	assign head_cur = head_q[deq_lv];
	assign wr_addr  = ADDR_W'(enq_lv) * ADDR_W'(CAPACITY) + ADDR_W'(tail_cur);
	assign rd_addr  = ADDR_W'(deq_lv) * ADDR_W'(CAPACITY) + ADDR_W'(head_cur);

	always_ff @(posedge clk) begin
		if (ctl.load) req_q <= req;
		if (enq_go)   mem[wr_addr] <= req_q.item_value;
		if (deq_go)   rd_data_q <= mem[rd_addr];
		if (ctl.exec) status_q <= status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				lcnt_q[i] <= '0;
			end
			total_q  <= '0;
			deq_ok_q <= 1'b0;
		end else begin
			if (ctl.exec) deq_ok_q <= deq_go;
			for (int i = 0; i < LEVELS; i++) begin
				if (enq_go && enq_lv == LV_W'(i)) begin
					tail_q[i] <= adv(tail_q[i]);
					lcnt_q[i] <= lcnt_q[i] + CNT_W'(1);
				end
				if (deq_go && deq_lv == LV_W'(i)) begin
					head_q[i] <= adv(head_q[i]);
					lcnt_q[i] <= lcnt_q[i] - CNT_W'(1);
				end
			end
			if (enq_go)      total_q <= total_q + CNT_W'(1);
			else if (deq_go) total_q <= total_q - CNT_W'(1);
		end
	end

	assign rsp.out_value = deq_ok_q ? rd_data_q : '0;
	assign rsp.status    = status_q;
	assign rsp.now_empty = (total_q == '0);
	assign rsp.now_full  = (total_q == CNT_W'(CAPACITY));
	assign rsp.occupancy = OCC_W'(total_q);

endmodule

// File: src/three_level_priority_queue_core.sv
// Top level of the three-level strict-priority queue.
// Each transaction is an enqueue (value into the FIFO of levels 1..3) or a
// dequeue (oldest value of the highest non-empty level); all levels share
// CAPACITY slots. A transaction is taken when start is high and busy low,
// and its result appears on rsp for one cycle with done high, in the
// respond state that follows the execute state; the receiver cannot stall
// it. busy is high only in the execute cycle, so a new transaction may
// start in the cycle its predecessor's result is shown. The command
// register is loaded at acceptance and only acted on in the execute cycle
// that follows. Rejected commands change nothing and report full, empty
// or bad priority in status.
module three_level_priority_queue_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tlpq_pkg::req_t req,
	output logic           done,
	output tlpq_pkg::rsp_t rsp
);
	import tlpq_pkg::*;

	dp_ctl_t ctl;

	tlpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	tlpq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
